// File: rtl/ssmm_pkg.sv
// Shared constants and types for the set statistics block.
// Used by every module under rtl; depends on nothing else.
package ssmm_pkg;

	localparam int MAX_ITEMS   = 64;
	localparam int VALUE_BITS  = 16;

	// Fixed widths of the interface fields.
	localparam int FIELD_W     = 16;
	localparam int MEAN_W      = 24;
	localparam int CFIELD_W    = 7;
	localparam int MEAN_FRAC   = 8;

	// Internal widths derived from the configuration.
	localparam int VAL_W   = VALUE_BITS;
	localparam int VX_W    = (VAL_W > FIELD_W) ? VAL_W : FIELD_W;
	localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
	localparam int IDX_W   = $clog2(MAX_ITEMS);
	localparam int SUM_W   = VAL_W + CNT_W;
	localparam int DVD_W   = SUM_W + MEAN_FRAC;
	localparam int QUO_W   = (DVD_W > MEAN_W) ? DVD_W : MEAN_W;
	localparam int STEP_W  = $clog2(QUO_W);

	// One entry of the distinct value table.
	typedef struct packed {
		logic [VAL_W-1:0] val;
		logic [CNT_W-1:0] freq;
	} entry_t;

endpackage

// File: rtl/ssmm_store.sv
// Distinct value table: one write port and one registered read port.
// Depends on ssmm_pkg for the entry type and depth.
module ssmm_store import ssmm_pkg::*; (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  entry_t           wdata,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr,
	output entry_t           rdata
);

	entry_t mem_q [MAX_ITEMS];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/ssmm_div.sv
// Restoring divider, one quotient bit per cycle, for the mean.
// Depends on ssmm_pkg for the operand widths.
module ssmm_div import ssmm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [QUO_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic             done,
	output logic [QUO_W-1:0] quotient
);

	logic [QUO_W-1:0]  dq_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [CNT_W:0]    shifted;
	logic [CNT_W:0]    diff;
	logic              ge;
	logic [CNT_W-1:0]  next_rem;

	// The remainder stays below the divisor, so the shifted value fits CNT_W+1 bits.
	always_comb begin
		shifted  = {rem_q, dq_q[QUO_W-1]};
		ge       = shifted >= {1'b0, dvs_q};
		diff     = shifted - {1'b0, dvs_q};
		next_rem = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + STEP_W'(1);
			if (cnt_q == STEP_W'(QUO_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// The dividend shifts out at the top while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[QUO_W-2:0], ge};
			rem_q <= next_rem;
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

// File: rtl/set_statistics_min_max_mean_mode.sv
// Set statistics: minimum, maximum, mean and mode of a set of values.
// Input channel: in_valid/in_ready carry sample_value and end_of_set. A value
// transfer adds the value to the open set; an end transfer closes the set.
// Output channel: out_valid/out_ready carry one result per mode value, in
// order of first appearance, with last_result set on the final one. An empty
// set gives one all-zero result with last_result set.
// in_ready is high only while the sequencer is idle. A value transfer searches
// the distinct value table entry by entry, reading each entry (S_RD) and then
// comparing it (S_CMP); a found value has its frequency raised by one, and a new
// value is written after the last entry. A dropped value (set already full) is
// not searched and only marks the set as overflowed. An end transfer makes a
// first table pass to find the highest frequency, overlapped with the serial
// divider (one quotient bit per cycle, QUO_W bits, 31 by default), then a second
// pass that emits results. When the receiver stalls, the second pass holds at
// the matching entry until the output register is free; nothing is lost. After
// the end item the counters, the minimum, maximum and sum and the overflow flag
// return to their reset values. Reset clears the counters and flags; the table
// needs no clearing pass, since only entries already written are read.
module set_statistics_min_max_mean_mode import ssmm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [FIELD_W-1:0]  sample_value,
	input  logic                end_of_set,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [FIELD_W-1:0]  min_value,
	output logic [FIELD_W-1:0]  max_value,
	output logic [MEAN_W-1:0]   mean_fixed,
	output logic [FIELD_W-1:0]  mode_value,
	output logic [CFIELD_W-1:0] mode_count,
	output logic [CFIELD_W-1:0] item_count,
	output logic                overflow,
	output logic                last_result
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_CMP,
		S_FRD,
		S_FCMP,
		S_DWAIT,
		S_ERD,
		S_ECMP,
		S_EMPTY
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] used_q;
	logic [VAL_W-1:0] min_q;
	logic [VAL_W-1:0] max_q;
	logic [SUM_W-1:0] sum_q;
	logic             dropped_q;
	logic [VAL_W-1:0] v_q;
	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] best_q;
	logic [CNT_W-1:0] ties_q;
	logic [CNT_W-1:0] n_q;
	logic             out_valid_q;

	logic [FIELD_W-1:0]  min_value_q;
	logic [FIELD_W-1:0]  max_value_q;
	logic [MEAN_W-1:0]   mean_fixed_q;
	logic [FIELD_W-1:0]  mode_value_q;
	logic [CFIELD_W-1:0] mode_count_q;
	logic [CFIELD_W-1:0] item_count_q;
	logic                overflow_q;
	logic                last_result_q;

	logic [VX_W-1:0]  in_x;
	logic [VAL_W-1:0] v_in;
	logic [VX_W-1:0]  min_x;
	logic [VX_W-1:0]  max_x;
	logic [VX_W-1:0]  mode_x;
	logic             in_xfer;
	logic             slot_free;
	logic             at_end;
	logic             hit;
	logic             load_out;

	logic             mem_we;
	logic             mem_re;
	logic [IDX_W-1:0] mem_waddr;
	entry_t           mem_wdata;
	entry_t           mem_rdata;

	logic             div_start;
	logic             div_done;
	logic [QUO_W-1:0] div_quo;

	always_comb begin
		in_x   = VX_W'(sample_value);
		v_in   = in_x[VAL_W-1:0];
		min_x  = VX_W'(min_q);
		max_x  = VX_W'(max_q);
		mode_x = VX_W'(mem_rdata.val);
	end

	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign at_end    = (k_q == used_q);
	assign hit       = (mem_rdata.val == v_q);
	assign div_start = in_xfer && end_of_set && (count_q != '0);
	assign load_out  = slot_free &&
		(state_q == S_EMPTY || (state_q == S_ECMP && mem_rdata.freq == best_q));

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = k_q[IDX_W-1:0];
		mem_wdata = '{val: v_q, freq: CNT_W'(1)};
		unique case (state_q)
			S_RD: begin
				if (at_end) begin
					mem_we    = 1'b1;
					mem_waddr = used_q[IDX_W-1:0];
				end else begin
					mem_re = 1'b1;
				end
			end
			S_CMP: begin
				if (hit) begin
					mem_we    = 1'b1;
					mem_wdata = '{val: v_q, freq: mem_rdata.freq + CNT_W'(1)};
				end
			end
			S_FRD, S_ERD: begin
				mem_re = !at_end;
			end
			default: begin
			end
		endcase
	end

	ssmm_store u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (k_q[IDX_W-1:0]),
		.rdata (mem_rdata)
	);

	ssmm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (QUO_W'({sum_q, MEAN_FRAC'(0)})),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			used_q      <= '0;
			min_q       <= '1;
			max_q       <= '0;
			sum_q       <= '0;
			dropped_q   <= 1'b0;
			v_q         <= '0;
			k_q         <= '0;
			best_q      <= '0;
			ties_q      <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						k_q <= '0;
						if (end_of_set) begin
							best_q  <= '0;
							ties_q  <= '0;
							n_q     <= '0;
							state_q <= (count_q == '0) ? S_EMPTY : S_FRD;
						end else if (count_q >= CNT_W'(MAX_ITEMS)) begin
							dropped_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
							v_q     <= v_in;
							if (v_in < min_q) begin
								min_q <= v_in;
							end
							if (v_in > max_q) begin
								max_q <= v_in;
							end
							sum_q   <= sum_q + SUM_W'(v_in);
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					if (at_end) begin
						used_q  <= used_q + CNT_W'(1);
						state_q <= S_IDLE;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (hit) begin
						state_q <= S_IDLE;
					end else begin
						k_q     <= k_q + CNT_W'(1);
						state_q <= S_RD;
					end
				end
				S_FRD: begin
					if (at_end) begin
						k_q     <= '0;
						state_q <= S_DWAIT;
					end else begin
						state_q <= S_FCMP;
					end
				end
				S_FCMP: begin
					// Track the highest frequency and how many entries share it.
					if (mem_rdata.freq > best_q) begin
						best_q <= mem_rdata.freq;
						ties_q <= CNT_W'(1);
					end else if (mem_rdata.freq == best_q) begin
						ties_q <= ties_q + CNT_W'(1);
					end
					k_q     <= k_q + CNT_W'(1);
					state_q <= S_FRD;
				end
				S_DWAIT: begin
					if (div_done) begin
						state_q <= S_ERD;
					end
				end
				S_ERD: begin
					if (at_end) begin
						count_q   <= '0;
						used_q    <= '0;
						min_q     <= '1;
						max_q     <= '0;
						sum_q     <= '0;
						dropped_q <= 1'b0;
						state_q   <= S_IDLE;
					end else begin
						state_q <= S_ECMP;
					end
				end
				S_ECMP: begin
					// A matching entry waits here until the output register is free.
					if (mem_rdata.freq != best_q || slot_free) begin
						if (load_out) begin
							n_q <= n_q + CNT_W'(1);
						end
						k_q     <= k_q + CNT_W'(1);
						state_q <= S_ERD;
					end
				end
				S_EMPTY: begin
					if (slot_free) begin
						dropped_q <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			overflow_q <= dropped_q;
			if (state_q == S_EMPTY) begin
				min_value_q   <= '0;
				max_value_q   <= '0;
				mean_fixed_q  <= '0;
				mode_value_q  <= '0;
				mode_count_q  <= '0;
				item_count_q  <= '0;
				last_result_q <= 1'b1;
			end else begin
				min_value_q   <= min_x[FIELD_W-1:0];
				max_value_q   <= max_x[FIELD_W-1:0];
				mean_fixed_q  <= div_quo[MEAN_W-1:0];
				mode_value_q  <= mode_x[FIELD_W-1:0];
				mode_count_q  <= CFIELD_W'(best_q);
				item_count_q  <= CFIELD_W'(count_q);
				last_result_q <= (n_q + CNT_W'(1) == ties_q);
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign min_value   = min_value_q;
	assign max_value   = max_value_q;
	assign mean_fixed  = mean_fixed_q;
	assign mode_value  = mode_value_q;
	assign mode_count  = mode_count_q;
	assign item_count  = item_count_q;
	assign overflow    = overflow_q;
	assign last_result = last_result_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ITEMS))
		else $error("accepted count exceeds capacity");

	a_used_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= count_q)
		else $error("distinct entries exceed accepted values");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || out_ready))
		else $error("result loaded over one not yet taken");

	a_div_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ECMP && load_out) |-> div_done)
		else $error("result emitted before the mean is ready");

	a_ties_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ECMP && load_out) |-> (n_q < ties_q))
		else $error("more mode results than tied entries");

endmodule
